// ----- design/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted insertion priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Field widths
  localparam int unsigned PrioW   = 7;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OccW    = 7;

  // Default queue depth
  localparam int unsigned DefDepth = 64;

  // Highest priority that an insert accepts
  localparam logic [PrioW-1:0] PrioMax = 7'd100;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Input transaction
  typedef struct packed {
    logic [0:0]       command;
    logic [PrioW-1:0] priority_in;
  } spq_in_t;

  // Output transaction
  typedef struct packed {
    logic [PrioW-1:0]   priority_out;
    logic [StatusW-1:0] status;
    logic [OccW-1:0]    occupancy;
  } spq_out_t;

  // Broadcast control for every cell of the row
  typedef struct packed {
    logic             insert_en;
    logic             remove_en;
    logic [PrioW-1:0] prio;
  } spq_cell_ctrl_t;

endpackage

// ----- design/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds an entry, compares it against the
// priority being inserted and shifts toward the back or the front.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                           clk_i,
  input  spq_pkg::spq_cell_ctrl_t        ctrl_i,
  input  logic                           valid_i,
  input  logic                           prev_ge_i,
  input  logic [spq_pkg::PrioW-1:0]      prev_entry_i,
  input  logic [spq_pkg::PrioW-1:0]      next_entry_i,
  output logic [spq_pkg::PrioW-1:0]      entry_o,
  output logic                           ge_o
);

  logic [spq_pkg::PrioW-1:0] entry_q;
  logic [spq_pkg::PrioW-1:0] entry_d;

  // Occupied entry that stays in front of the new priority
  assign ge_o    = valid_i && (entry_q >= ctrl_i.prio);
  assign entry_o = entry_q;

  // Hold, take the new priority, or shift from a neighbor
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert_en) begin
      if (!ge_o) begin
        entry_d = prev_ge_i ? ctrl_i.prio : prev_entry_i;
      end
    end else if (ctrl_i.remove_en) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ----- design/sorted_insertion_priority_queue_top.sv -----
// ----------------------------------------------------------------------------
// sorted_insertion_priority_queue_top
// Priority queue kept in descending order in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_stall_o / in_data_i) carries one
//   command per transaction: insert priority_in, or remove the front entry.
//   Every command yields one output transaction (out_valid_o / out_stall_i /
//   out_data_o) with the removed priority, a status code and the occupancy.
//   Throughput is one command per cycle unless the receiver stalls: every
//   cell compares against the broadcast priority and shifts in the same
//   cycle, so the whole row updates at once.
//   Results sit in an output register; while the receiver stalls with a
//   result pending, in_stall_o is raised and no new command is taken.
//   Reset empties the queue (occupancy zero) and drops any pending result;
//   entry contents are not cleared, as unoccupied cells never reach a result.
//   Inserts above the priority limit, inserts into a full queue and removes
//   from an empty queue leave the queue unchanged and report their status.
// ----------------------------------------------------------------------------
module sorted_insertion_priority_queue_top #(
  parameter int unsigned DEPTH = spq_pkg::DefDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  spq_pkg::spq_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output spq_pkg::spq_out_t out_data_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]            count_q;
  logic [CntW-1:0]            count_d;
  logic                       out_valid_q;
  spq_pkg::spq_out_t          out_data_q;
  spq_pkg::spq_out_t          out_data_d;
  logic                       accept;
  spq_pkg::spq_cell_ctrl_t    ctrl;
  spq_pkg::status_e           status;
  logic [spq_pkg::PrioW-1:0]  prio_out;
  logic [spq_pkg::PrioW-1:0]  entry   [DEPTH];
  logic                       ge      [DEPTH];

  // Take a new transaction unless a result waits on a stalled receiver
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Decode the command against the current fill level
  always_comb begin
    ctrl.insert_en = 1'b0;
    ctrl.remove_en = 1'b0;
    ctrl.prio      = in_data_i.priority_in;
    status         = spq_pkg::ST_OK;
    prio_out       = '0;
    count_d        = count_q;
    if (spq_pkg::cmd_e'(in_data_i.command) == spq_pkg::CMD_INSERT) begin
      if (in_data_i.priority_in > spq_pkg::PrioMax) begin
        status = spq_pkg::ST_RANGE;
      end else if (count_q == CntW'(DEPTH)) begin
        status = spq_pkg::ST_FULL;
      end else begin
        ctrl.insert_en = accept;
        count_d        = count_q + 1'b1;
      end
    end else begin
      if (count_q == '0) begin
        status = spq_pkg::ST_EMPTY;
      end else begin
        ctrl.remove_en = accept;
        prio_out       = entry[0];
        count_d        = count_q - 1'b1;
      end
    end
    out_data_d.priority_out = prio_out;
    out_data_d.status       = status;
    out_data_d.occupancy    = spq_pkg::OccW'(count_d);
  end

  // Row of cells, front at index zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                      valid;
    logic                      prev_ge;
    logic [spq_pkg::PrioW-1:0] prev_entry;
    logic [spq_pkg::PrioW-1:0] next_entry;

    assign valid = count_q > CntW'(i);

    if (i == 0) begin : g_front
      assign prev_ge    = 1'b1;
      assign prev_entry = in_data_i.priority_in;
    end else begin : g_body
      assign prev_ge    = ge[i-1];
      assign prev_entry = entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_back
      assign next_entry = entry[i];
    end else begin : g_inner
      assign next_entry = entry[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .valid_i      (valid),
      .prev_ge_i    (prev_ge),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .entry_o      (entry[i]),
      .ge_o         (ge[i])
    );
  end

  // Advance the fill count and the output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result register on every accepted transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
